FILE: rtl/core/hldf_pkg.sv
package hldf_pkg;

    localparam int FRAME_CAPACITY_DEF = 16;
    localparam int CHANNELS_DEF       = 2;
    localparam int MAX_RESULTS        = 16;
    localparam int RES_CNT_W          = $clog2(MAX_RESULTS + 1);

    localparam logic [7:0] HDR_FIRST_RST  = 8'h77;
    localparam logic [7:0] HDR_SECOND_RST = 8'h68;
    localparam logic [7:0] TAIL_RST       = 8'h0A;
    localparam logic [4:0] MIN_LEN_RST    = 5'd6;
    localparam logic [4:0] MIN_LEN_FLOOR  = 5'd3;

    typedef enum logic [2:0] {
        KIND_FRAME    = 3'd0,
        KIND_HEADER   = 3'd1,
        KIND_LENGTH   = 3'd2,
        KIND_TAIL     = 3'd3,
        KIND_OVERFLOW = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        REG_HDR_FIRST  = 2'd0,
        REG_HDR_SECOND = 2'd1,
        REG_TAIL       = 2'd2,
        REG_MIN_LEN    = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_HDR0,
        S_HDR1,
        S_LEN,
        S_TAIL,
        S_EMIT,
        S_FINISH
    } scan_state_t;

    typedef struct packed {
        logic [7:0] hdr_first;
        logic [7:0] hdr_second;
        logic [7:0] tail;
        logic [4:0] min_len;
    } cfg_t;

    typedef struct packed {
        logic       port;
        kind_t      kind;
        logic [7:0] data;
        logic [3:0] pos;
        logic       fend;
    } result_t;

    typedef struct packed {
        logic push;
        logic flush;
    } emit_ctrl_t;

    typedef struct packed {
        logic room;
        logic slot_free;
        logic pend_valid;
    } emit_stat_t;

endpackage

FILE: rtl/core/hldf_rx_if.sv
interface hldf_rx_if;
    logic       valid;
    logic       ready;
    logic       port_index;
    logic [7:0] rx_byte;

    modport source (output valid, output port_index, output rx_byte, input ready);
    modport sink (input valid, input port_index, input rx_byte, output ready);
endinterface

FILE: rtl/core/hldf_ev_if.sv
interface hldf_ev_if;
    logic       valid;
    logic       ready;
    logic       out_port;
    logic [2:0] event_kind;
    logic [7:0] event_byte;
    logic [3:0] byte_position;
    logic       frame_end;
    logic       run_end;

    modport source (output valid, output out_port, output event_kind, output event_byte,
                    output byte_position, output frame_end, output run_end, input ready);
    modport sink (input valid, input out_port, input event_kind, input event_byte,
                  input byte_position, input frame_end, input run_end, output ready);
endinterface

FILE: rtl/core/hldf_cfg.sv
module hldf_cfg
    import hldf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    output cfg_t       cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hdr_first  <= HDR_FIRST_RST;
            cfg_reg.hdr_second <= HDR_SECOND_RST;
            cfg_reg.tail       <= TAIL_RST;
            cfg_reg.min_len    <= MIN_LEN_RST;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_HDR_FIRST:  cfg_reg.hdr_first  <= cfg_data;
                REG_HDR_SECOND: cfg_reg.hdr_second <= cfg_data;
                REG_TAIL:       cfg_reg.tail       <= cfg_data;
                REG_MIN_LEN:    cfg_reg.min_len    <= cfg_data[4:0];
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/core/hldf_scan.sv
module hldf_scan
    import hldf_pkg::*;
#(
    parameter int FRAME_CAPACITY = FRAME_CAPACITY_DEF,
    parameter int CHANNELS       = CHANNELS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    hldf_rx_if.sink    rx_ch,
    input  cfg_t       cfg,
    input  emit_stat_t stat,
    output emit_ctrl_t ctrl,
    output result_t    res
);

    localparam int IDX_W = $clog2(FRAME_CAPACITY);
    localparam int CNT_W = $clog2(FRAME_CAPACITY + 1);
    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DEPTH = CHANNELS * FRAME_CAPACITY;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [IDX_W:0]   CAP_EXT   = (IDX_W + 1)'(FRAME_CAPACITY);
    localparam logic [CNT_W-1:0] CAP_CNT   = CNT_W'(FRAME_CAPACITY);
    localparam logic [7:0]       CAP_BYTE  = 8'(FRAME_CAPACITY);
    localparam logic [CNT_W-1:0] SCAN_FILL = CNT_W'(3);

    scan_state_t state_reg, state_next;
    logic [CH_W-1:0]      ch_reg, ch_next;
    logic [7:0]           b0_reg, b0_next;
    logic [CNT_W-1:0]     len_reg, len_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [RES_CNT_W-1:0] res_cnt_reg;
    logic [CNT_W-1:0]     fill_reg [CHANNELS];
    logic [IDX_W-1:0]     head_reg [CHANNELS];

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    logic             port_ok;
    logic [CH_W-1:0]  in_ch;
    logic [CNT_W-1:0] in_fill;
    logic [IDX_W-1:0] in_head;
    logic [CNT_W-1:0] cur_fill;
    logic [IDX_W-1:0] cur_head;
    logic [7:0]       min_byte;
    logic             cnt_full;
    logic             emit_ok;
    logic             want;
    logic             frame_last;

    logic             wr_en;
    logic             append;
    logic             ovf_clear;
    logic             rd_en;
    logic [IDX_W-1:0] rd_off;
    logic             drop_en;
    logic [CNT_W-1:0] drop_cnt;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;
    logic [IDX_W-1:0] head_after_drop;

    function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W:0] s);
        return (s >= CAP_EXT) ? IDX_W'(s - CAP_EXT) : s[IDX_W-1:0];
    endfunction

    function automatic logic [AW-1:0] mem_addr(input logic [CH_W-1:0] ch,
                                               input logic [IDX_W-1:0] idx);
        return AW'(ch) * AW'(FRAME_CAPACITY) + AW'(idx);
    endfunction

    assign port_ok  = (32'(rx_ch.port_index) < 32'(CHANNELS));
    assign in_ch    = CH_W'(rx_ch.port_index);
    assign in_fill  = fill_reg[in_ch];
    assign in_head  = head_reg[in_ch];
    assign cur_fill = fill_reg[ch_reg];
    assign cur_head = head_reg[ch_reg];
    assign min_byte = 8'((cfg.min_len < MIN_LEN_FLOOR) ? MIN_LEN_FLOOR : cfg.min_len);
    assign cnt_full = (res_cnt_reg == RES_CNT_W'(MAX_RESULTS));
    // once the result budget is spent the scan keeps going without output
    assign emit_ok  = stat.room || cnt_full;
    assign frame_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == len_reg);

    assign wr_addr = mem_addr(in_ch, wrap_idx((IDX_W + 1)'(in_head) + (IDX_W + 1)'(in_fill)));
    assign rd_addr = mem_addr(ch_reg, wrap_idx((IDX_W + 1)'(cur_head) + (IDX_W + 1)'(rd_off)));
    assign head_after_drop = wrap_idx((IDX_W + 1)'(cur_head) + (IDX_W + 1)'(drop_cnt));

    always_comb
    begin
        state_next  = state_reg;
        ch_next     = ch_reg;
        b0_next     = b0_reg;
        len_next    = len_reg;
        idx_next    = idx_reg;
        rx_ch.ready = 1'b0;
        wr_en       = 1'b0;
        append      = 1'b0;
        ovf_clear   = 1'b0;
        rd_en       = 1'b0;
        rd_off      = '0;
        drop_en     = 1'b0;
        drop_cnt    = '0;
        want        = 1'b0;
        ctrl.flush  = 1'b0;
        res.port    = ch_reg[0];
        res.kind    = KIND_FRAME;
        res.data    = rdata_reg;
        res.pos     = '0;
        res.fend    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                rx_ch.ready = 1'b1;
                if (rx_ch.valid && port_ok)
                begin
                    ch_next = in_ch;
                    if (in_fill == CAP_CNT)
                    begin
                        ovf_clear  = 1'b1;
                        want       = 1'b1;
                        res.port   = rx_ch.port_index;
                        res.kind   = KIND_OVERFLOW;
                        res.data   = rx_ch.rx_byte;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        append     = 1'b1;
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (cur_fill < SCAN_FILL)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_HDR0;
                end
            end
            S_HDR0:
            begin
                b0_next    = rdata_reg;
                rd_en      = 1'b1;
                rd_off     = IDX_W'(1);
                state_next = S_HDR1;
            end
            S_HDR1:
            begin
                if (b0_reg != cfg.hdr_first || rdata_reg != cfg.hdr_second)
                begin
                    want     = 1'b1;
                    res.kind = KIND_HEADER;
                    res.data = b0_reg;
                    if (emit_ok)
                    begin
                        drop_en    = 1'b1;
                        drop_cnt   = CNT_W'(1);
                        state_next = S_CHECK;
                    end
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_off     = IDX_W'(2);
                    state_next = S_LEN;
                end
            end
            S_LEN:
            begin
                if (rdata_reg < min_byte || rdata_reg > CAP_BYTE)
                begin
                    want     = 1'b1;
                    res.kind = KIND_LENGTH;
                    if (emit_ok)
                    begin
                        drop_en    = 1'b1;
                        drop_cnt   = CNT_W'(2);
                        state_next = S_CHECK;
                    end
                end
                else if (8'(cur_fill) < rdata_reg)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    len_next   = CNT_W'(rdata_reg);
                    rd_en      = 1'b1;
                    rd_off     = IDX_W'(rdata_reg - 8'd1);
                    state_next = S_TAIL;
                end
            end
            S_TAIL:
            begin
                if (rdata_reg != cfg.tail)
                begin
                    want     = 1'b1;
                    res.kind = KIND_TAIL;
                    res.data = b0_reg;
                    if (emit_ok)
                    begin
                        drop_en    = 1'b1;
                        drop_cnt   = CNT_W'(1);
                        state_next = S_CHECK;
                    end
                end
                else
                begin
                    rd_en      = 1'b1;
                    idx_next   = '0;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                want     = 1'b1;
                res.pos  = 4'(idx_reg);
                res.fend = frame_last;
                if (emit_ok)
                begin
                    if (frame_last)
                    begin
                        drop_en    = 1'b1;
                        drop_cnt   = len_reg;
                        state_next = S_CHECK;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_off   = idx_reg + IDX_W'(1);
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            S_FINISH:
            begin
                // last result of the transfer leaves with run_end set
                if (!stat.pend_valid)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.slot_free)
                begin
                    ctrl.flush = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        ctrl.push = want && stat.room && !cnt_full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ch_reg      <= '0;
            res_cnt_reg <= '0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                fill_reg[c] <= '0;
                head_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
            if (state_next == S_IDLE)
            begin
                res_cnt_reg <= '0;
            end
            else if (ctrl.push)
            begin
                res_cnt_reg <= res_cnt_reg + RES_CNT_W'(1);
            end
            if (append)
            begin
                fill_reg[in_ch] <= in_fill + CNT_W'(1);
            end
            else if (ovf_clear)
            begin
                fill_reg[in_ch] <= '0;
            end
            else if (drop_en)
            begin
                fill_reg[ch_reg] <= cur_fill - drop_cnt;
                head_reg[ch_reg] <= head_after_drop;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        b0_reg  <= b0_next;
        len_reg <= len_next;
        idx_reg <= idx_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= rx_ch.rx_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/core/hldf_emit.sv
module hldf_emit
    import hldf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  emit_ctrl_t ctrl,
    input  result_t    res,
    output emit_stat_t stat,
    hldf_ev_if.source  ev_ch
);

    result_t pend_reg;
    logic    pend_valid_reg;
    result_t out_reg;
    logic    out_last_reg;
    logic    out_valid_reg;
    logic    slot_free;
    logic    move;

    // a result waits in pend until the next one shows whether it was the last
    assign slot_free = !out_valid_reg || ev_ch.ready;
    assign move      = pend_valid_reg && (ctrl.push || ctrl.flush);

    assign stat.room       = !pend_valid_reg || slot_free;
    assign stat.slot_free  = slot_free;
    assign stat.pend_valid = pend_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (ctrl.push)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (ctrl.flush)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (ev_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            pend_reg <= res;
        end
        if (move)
        begin
            out_reg      <= pend_reg;
            out_last_reg <= ctrl.flush;
        end
    end

    assign ev_ch.valid         = out_valid_reg;
    assign ev_ch.out_port      = out_reg.port;
    assign ev_ch.event_kind    = out_reg.kind;
    assign ev_ch.event_byte    = out_reg.data;
    assign ev_ch.byte_position = out_reg.pos;
    assign ev_ch.frame_end     = out_reg.fend;
    assign ev_ch.run_end       = out_last_reg;

endmodule

FILE: rtl/core/header_length_tail_deframer_unit.sv
// Byte deframer with one buffer per channel.
// rx_ch carries one received byte and its channel; ev_ch returns frame bytes
// (kind 0, with position and frame_end) and drop events, each with run_end set
// on the last result caused by an input byte. A transfer on rx_ch is taken
// only when the scan of the previous byte is finished; results then drain
// through a one-deep holding stage and the output register.
// Per byte: the byte is stored (a byte for a full buffer instead empties it
// with an overflow event and goes straight to closing), then the buffered
// bytes are rescanned through the single-port byte memory, one byte read per
// cycle at most: after each header, length or tail drop and after each frame
// the check starts again, until fewer than three bytes remain or an incomplete
// frame is found; a closing step then ends the transfer.
// A stalled ev_ch holds the scan at its next result; nothing is lost.
// Reset empties every channel buffer and loads the default header, tail and
// minimum length. Configuration writes belong to idle periods.
module header_length_tail_deframer_unit
    import hldf_pkg::*;
#(
    parameter int FRAME_CAPACITY = FRAME_CAPACITY_DEF,
    parameter int CHANNELS       = CHANNELS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    hldf_rx_if.sink    rx_ch,
    hldf_ev_if.source  ev_ch,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    cfg_t       cfg;
    emit_ctrl_t ctrl;
    emit_stat_t stat;
    result_t    res;

    hldf_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hldf_scan #(
        .FRAME_CAPACITY (FRAME_CAPACITY),
        .CHANNELS       (CHANNELS)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .rx_ch (rx_ch),
        .cfg   (cfg),
        .stat  (stat),
        .ctrl  (ctrl),
        .res   (res)
    );

    hldf_emit u_emit (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .res   (res),
        .stat  (stat),
        .ev_ch (ev_ch)
    );

    a_push_flush_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.push && ctrl.flush))
        else $error("push and flush in the same cycle");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.push |-> stat.room)
        else $error("result pushed without room");

    a_accept_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (rx_ch.valid && rx_ch.ready) |-> !stat.pend_valid)
        else $error("byte taken while a result is still held");

    a_flush_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.flush |=> (ev_ch.valid && ev_ch.run_end))
        else $error("closing result not presented with run_end");

endmodule
